// ----- src/ccbs_pkg.sv -----
// Package for the closed cubic B-spline sampler: widths, op codes and helpers.
// Used by ccbs_lane and the top level; depends on nothing.
package ccbs_pkg;
   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 16;
   localparam int IDX_BITS   = $clog2(MAX_POINTS);
   localparam int PC_BITS    = 7;
   localparam int NS_BITS    = 6;
   localparam int W_BITS     = 3 * NS_BITS + 3;
   localparam int PROD_BITS  = W_BITS + COORD_BITS + 1;
   localparam int ACC_BITS   = PROD_BITS + 2;
   localparam int DEN_BITS   = 3 * NS_BITS + 3;
   localparam int Q_BITS     = ACC_BITS;
   localparam int PT_BITS    = 3 * COORD_BITS;
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_GEN   = 1'b1;
   localparam logic [PC_BITS-1:0] PC_RESET = 7'd4;
   localparam logic [NS_BITS-1:0] NS_RESET = 6'd20;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // weights for one step k of n, scaled by 6*n^3
   typedef struct packed {
      logic signed [W_BITS-1:0] w0;
      logic signed [W_BITS-1:0] w1;
      logic signed [W_BITS-1:0] w2;
      logic signed [W_BITS-1:0] w3;
   } weights_type;
endpackage

// ----- src/ccbs_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module ccbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- src/ccbs_lane.sv -----
// One coordinate lane: weighted sum of four points, then rounded division.
// Depends on ccbs_pkg.
module ccbs_lane import ccbs_pkg::*; (
   input  logic                       clock,
   input  logic                       clr,
   input  logic                       mac_en,
   input  logic signed [W_BITS-1:0]   w,
   input  coord_type                  p,
   input  logic                       div_start,
   input  logic [DEN_BITS-1:0]        den,
   output logic                       div_busy,
   output coord_type                  result
);
   logic signed [PROD_BITS-1:0] prod_ff;
   logic                        pv_ff;
   logic signed [ACC_BITS-1:0]  acc_ff;
   logic                        neg_ff;
   logic [Q_BITS:0]             rem_ff;
   logic [Q_BITS-1:0]           num_ff, q_ff;
   logic [DEN_BITS:0]           d2_ff;
   logic [$clog2(Q_BITS+1)-1:0] cnt_ff;
   logic                        busy_ff;
   logic [Q_BITS:0]             trial;
   logic [Q_BITS-1:0]           mag;
   logic signed [Q_BITS:0]      sq;

   assign trial = {rem_ff[Q_BITS-1:0], num_ff[Q_BITS-1]};
   // |acc|*2 + den, fits since |acc| << 2^(ACC_BITS-2)
   assign mag = (acc_ff[ACC_BITS-1] ? Q_BITS'(-acc_ff) : Q_BITS'(acc_ff));

   always_ff @(posedge clock) begin
      prod_ff <= PROD_BITS'(w * p);
      pv_ff   <= mac_en;
      if (clr) acc_ff <= '0;
      else if (pv_ff) acc_ff <= acc_ff + ACC_BITS'(prod_ff);
      if (clr) busy_ff <= 1'b0;
      else if (div_start) begin
         busy_ff <= 1'b1;
         neg_ff  <= acc_ff[ACC_BITS-1];
         num_ff  <= Q_BITS'({mag, 1'b0} + Q_BITS'(den));
         d2_ff   <= {den, 1'b0};
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[Q_BITS-2:0], 1'b0};
         if (trial >= (Q_BITS+1)'(d2_ff)) begin
            rem_ff <= trial - (Q_BITS+1)'(d2_ff);
            q_ff   <= {q_ff[Q_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            q_ff   <= {q_ff[Q_BITS-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(Q_BITS+1))'(Q_BITS-1)) busy_ff <= 1'b0;
      end
   end
   assign div_busy = busy_ff;

   always_comb begin
      sq = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
      if (sq > (Q_BITS+1)'(signed'(2**(COORD_BITS-1)-1)))
         result = coord_type'(2**(COORD_BITS-1)-1);
      else if (sq < -(Q_BITS+1)'(signed'(2**(COORD_BITS-1))))
         result = coord_type'(-(2**(COORD_BITS-1)));
      else result = coord_type'(sq);
   end
endmodule

// ----- src/closed_cubic_bspline_sampler.sv -----
// Top level of the closed cubic B-spline sampler: control, store, lanes.
// Depends on ccbs_pkg, ccbs_ram and ccbs_lane.
//
// Usage:
//  req_ channel: op=0 loads point (px,py,pz) into slot index,
//   no result. op=1 generates segment index: n+1 rsp_ beats, n set by
//   points_per_segment (0 acts as 1), the last with rsp_last_point.
//   An index not below point_count gives one beat with rsp_bad_index,
//   valid the cycle after its request beat.
//  csr_: write enable, index (0 point_count, 1 points_per_segment), data.
//  Each curve point is built in steps: the weights are built first, then
//  four store reads feed three coordinate lanes (one multiply-accumulate
//  each per read), then a 40-bit radix-2 restoring divider per lane runs
//  (one quotient bit a cycle), then the beat is parked in the output
//  register. req_ready stays low from a generate beat until its last
//  rsp_ beat is taken. The next point's work starts only once the output
//  register is free, so a stalled receiver simply holds the block.
//  Merge: the three lanes' results join into one output beat.
//  Reset clears control and the registers to 4 and 20; the point store
//  has no reset and must be loaded before use.
module closed_cubic_bspline_sampler import ccbs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [5:0]        req_index,
   input  coord_type         req_px,
   input  coord_type         req_py,
   input  coord_type         req_pz,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output coord_type         rsp_cx,
   output coord_type         rsp_cy,
   output coord_type         rsp_cz,
   output logic              rsp_last_point,
   output logic              rsp_bad_index,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [PC_BITS-1:0] csr_wr_data
);
   localparam logic [2:0] ST_IDLE = 3'd0, ST_WGT = 3'd1, ST_MAC = 3'd2,
                          ST_DIV = 3'd3, ST_OUT = 3'd4;
   localparam logic CSR_PC = 1'b0, CSR_NS = 1'b1;

   logic [2:0]           state_ff, state_in;
   logic [PC_BITS-1:0]   pc_ff;
   logic [NS_BITS-1:0]   ns_ff;
   logic [IDX_BITS:0]    pc_eff;
   logic [NS_BITS-1:0]   n_ff, k_ff;
   logic [IDX_BITS-1:0]  base_ff, slot_ff;
   logic [2:0]           step_ff;
   logic [DEN_BITS-1:0]  den_ff;
   weights_type          wt_ff;
   logic [1:0]           ph_ff;
   logic                 rv_ff;
   logic                 bad_ff, lastp_ff;
   coord_type            ox_ff, oy_ff, oz_ff;
   logic [PT_BITS-1:0]   rd_data;
   logic                 busy_x, busy_y, busy_z;
   coord_type            rx, ry, rz;
   logic signed [W_BITS-1:0] wsel;
   logic                 mac_en, clr, dstart;
   logic                 accept, rsp_free;

   // multiplier stage for weights (products of k, n and n-k)
   logic [W_BITS-1:0]    m1_ff;
   logic [W_BITS-1:0]    k2_ff, k3_ff, n2_ff, n3_ff, nk3_ff, kn2_ff, k2n_ff;

   assign pc_eff   = (pc_ff > PC_BITS'(MAX_POINTS)) ? (IDX_BITS+1)'(MAX_POINTS)
                                                    : (IDX_BITS+1)'(pc_ff);
   assign req_ready = (state_ff == ST_IDLE) && !rv_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rv_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_RESET;
         ns_ff <= NS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PC: pc_ff <= csr_wr_data;
            CSR_NS: ns_ff <= csr_wr_data[NS_BITS-1:0];
            default: ;
         endcase
      end
   end

   ccbs_ram #(.WIDTH(PT_BITS), .DEPTH(MAX_POINTS)) u_store (
      .clock  (clock),
      .wr_en  (accept && req_op == OP_LOAD),
      .wr_addr(req_index[IDX_BITS-1:0]),
      .wr_data({req_px, req_py, req_pz}),
      .rd_addr(slot_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      unique case (ph_ff)
         2'd0: wsel = wt_ff.w0;
         2'd1: wsel = wt_ff.w1;
         2'd2: wsel = wt_ff.w2;
         default: wsel = wt_ff.w3;
      endcase
   end

   // lanes: RAM data valid in the cycle after the address, so mac_en delayed
   logic mac_d_ff;
   assign mac_en = mac_d_ff;
   assign clr    = (state_ff == ST_WGT);
   assign dstart = (state_ff == ST_MAC) && (step_ff == 3'd6);

   ccbs_lane u_lx (.clock(clock), .clr(clr), .mac_en(mac_en), .w(wsel),
      .p(rd_data[3*COORD_BITS-1:2*COORD_BITS]), .div_start(dstart),
      .den(den_ff), .div_busy(busy_x), .result(rx));
   ccbs_lane u_ly (.clock(clock), .clr(clr), .mac_en(mac_en), .w(wsel),
      .p(rd_data[2*COORD_BITS-1:COORD_BITS]), .div_start(dstart),
      .den(den_ff), .div_busy(busy_y), .result(ry));
   ccbs_lane u_lz (.clock(clock), .clr(clr), .mac_en(mac_en), .w(wsel),
      .p(rd_data[COORD_BITS-1:0]), .div_start(dstart),
      .den(den_ff), .div_busy(busy_z), .result(rz));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && req_op == OP_GEN &&
                      (IDX_BITS+1)'(req_index) < pc_eff) state_in = ST_WGT;
         ST_WGT:  if (step_ff == 3'd5) state_in = ST_MAC;
         ST_MAC:  if (step_ff == 3'd6) state_in = ST_DIV;
         ST_DIV:  if (!busy_x && !busy_y && !busy_z && !dstart) state_in = ST_OUT;
         ST_OUT:  if (rsp_free) state_in = (k_ff == n_ff) ? ST_IDLE : ST_WGT;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         step_ff  <= '0;
         mac_d_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mac_d_ff <= (state_ff == ST_MAC) && (step_ff < 3'd4);
         if (state_ff != state_in) step_ff <= '0;
         else step_ff <= step_ff + 1'b1;
         // a new beat enters the output register, else a taken one leaves
         if ((accept && req_op == OP_GEN && (IDX_BITS+1)'(req_index) >= pc_eff) ||
             (state_ff == ST_OUT && rsp_free))
            rv_ff <= 1'b1;
         else if (rv_ff && rsp_ready)
            rv_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept && req_op == OP_GEN) begin
         n_ff     <= (ns_ff == '0) ? NS_BITS'(1) : ns_ff;
         k_ff     <= '0;
         base_ff  <= req_index[IDX_BITS-1:0];
         bad_ff   <= 1'b1;
         lastp_ff <= 1'b1;
         ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
      end
      unique case (state_ff)
         ST_WGT: begin
            ph_ff   <= '0;
            // weights built step by step from products of k, n and n-k
            unique case (step_ff)
               3'd0: begin
                  k2_ff  <= W_BITS'(k_ff) * W_BITS'(k_ff);
                  n2_ff  <= W_BITS'(n_ff) * W_BITS'(n_ff);
                  m1_ff  <= W_BITS'(n_ff - k_ff) * W_BITS'(n_ff - k_ff);
               end
               3'd1: begin
                  k3_ff  <= k2_ff * W_BITS'(k_ff);
                  n3_ff  <= n2_ff * W_BITS'(n_ff);
                  nk3_ff <= m1_ff * W_BITS'(n_ff - k_ff);
               end
               3'd2: begin
                  k2n_ff <= k2_ff * W_BITS'(n_ff);
                  kn2_ff <= n2_ff * W_BITS'(k_ff);
                  den_ff <= DEN_BITS'(n3_ff * 6);
               end
               3'd3: begin
                  wt_ff.w0 <= signed'(nk3_ff);
                  wt_ff.w1 <= signed'(W_BITS'(3 * k3_ff - 6 * k2n_ff + 4 * n3_ff));
                  wt_ff.w2 <= signed'(W_BITS'(-3 * k3_ff + 3 * k2n_ff
                                              + 3 * kn2_ff + n3_ff));
                  wt_ff.w3 <= signed'(k3_ff);
               end
               default: ;
            endcase
         end
         ST_MAC: if (mac_d_ff) ph_ff <= ph_ff + 1'b1;
         ST_OUT: if (rsp_free) begin
            ox_ff <= rx; oy_ff <= ry; oz_ff <= rz;
            lastp_ff <= (k_ff == n_ff);
            bad_ff   <= 1'b0;
            k_ff     <= k_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // slot walk: issue base..base+3 mod point_count during MAC steps 0..3
   logic [IDX_BITS-1:0] walk_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_WGT) walk_ff <= base_ff;
      else if (state_ff == ST_MAC && step_ff < 3'd4)
         walk_ff <= ((IDX_BITS+1)'(walk_ff) + 1'b1 >= pc_eff) ? '0
                    : walk_ff + 1'b1;
   end
   always_comb slot_ff = walk_ff;

   assign rsp_valid      = rv_ff;
   assign rsp_cx         = ox_ff;
   assign rsp_cy         = oy_ff;
   assign rsp_cz         = oz_ff;
   assign rsp_last_point = lastp_ff;
   assign rsp_bad_index  = bad_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready) else $error("accept while busy");
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rv_ff && bad_ff |-> lastp_ff) else $error("bad beat not last");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_ready |=> rv_ff && $stable(ox_ff)) else $error("beat lost");
endmodule
